// ===== rtl/sat_pkg.sv =====
package sat_pkg;

    // Table geometry and address width of the translated result
    localparam int SEGMENTS   = 16;
    localparam int ADDR_WIDTH = 16;

    // Field widths fixed by the interface
    localparam int DATA_W     = 16;
    localparam int ID_W       = 8;
    localparam int SLOT_W     = 4;
    localparam int SLOT_IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CNT_W      = $clog2(DATA_W + 1);

    localparam logic [DATA_W-1:0] MAX_SEG_RESET = 16'd64;

    // Mask applied to base + offset (17-bit sum)
    localparam logic [DATA_W:0] ADDR_MASK =
        (ADDR_WIDTH > DATA_W) ? {(DATA_W+1){1'b1}}
                              : (DATA_W+1)'(((DATA_W+1)'(1) << ADDR_WIDTH) - 1);

    // Action codes
    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
    } t_slot_entry;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] slot;
        t_slot_entry           entry;
    } t_slot_write;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
    } t_lookup_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/sat_divider.sv =====
module sat_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sat_pkg::DATA_W-1:0] i_dividend,
    input  logic [sat_pkg::DATA_W-1:0] i_divisor,
    output sat_pkg::t_div_status       o_status,
    output logic [sat_pkg::DATA_W-1:0] o_quotient,
    output logic [sat_pkg::DATA_W-1:0] o_remainder
);

    logic [sat_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_done;
    logic [sat_pkg::DATA_W-1:0] r_rem;
    logic [sat_pkg::DATA_W-1:0] r_quo;
    logic [sat_pkg::DATA_W-1:0] r_div;

    logic [sat_pkg::DATA_W:0]   trial;
    logic [sat_pkg::DATA_W:0]   diff;
    logic                       ge;
    logic                       busy;

    // One quotient bit per cycle: shift in the next dividend bit, try subtract.
    assign busy  = (r_cnt != '0);
    assign trial = {r_rem, r_quo[sat_pkg::DATA_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= busy && (r_cnt == sat_pkg::CNT_W'(1));
            if (i_start) begin
                r_cnt <= sat_pkg::CNT_W'(sat_pkg::DATA_W);
            end else if (busy) begin
                r_cnt <= r_cnt - sat_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (busy) begin
            r_rem <= ge ? diff[sat_pkg::DATA_W-1:0] : trial[sat_pkg::DATA_W-1:0];
            r_quo <= {r_quo[sat_pkg::DATA_W-2:0], ge};
        end
    end

    assign o_status.busy = busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;

endmodule

// ===== rtl/sat_lookup.sv =====
module sat_lookup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sat_pkg::t_slot_write       i_write,
    input  logic                       i_search,
    input  logic [sat_pkg::DATA_W-1:0] i_key,
    output sat_pkg::t_lookup_result    o_result
);

    logic                         r_valid [sat_pkg::SEGMENTS];
    logic [sat_pkg::ID_W-1:0]     r_id    [sat_pkg::SEGMENTS];
    logic [sat_pkg::DATA_W-1:0]   r_base  [sat_pkg::SEGMENTS];
    logic [sat_pkg::DATA_W-1:0]   r_size  [sat_pkg::SEGMENTS];

    sat_pkg::t_lookup_result      r_result;
    logic                         hit;
    logic [sat_pkg::SLOT_IDX_W-1:0] hit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sat_pkg::SEGMENTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_write.en) begin
            r_valid[i_write.slot] <= i_write.entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_write.en) begin
            r_id[i_write.slot]   <= i_write.entry.id;
            r_base[i_write.slot] <= i_write.entry.base;
            r_size[i_write.slot] <= i_write.entry.size;
        end
    end

    // Lowest-numbered live slot whose id equals the key wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = sat_pkg::SEGMENTS - 1; i >= 0; i--) begin
            if (r_valid[i] && (i_key == sat_pkg::DATA_W'(r_id[i]))) begin
                hit     = 1'b1;
                hit_idx = sat_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_search) begin
            r_result.hit  <= hit;
            r_result.base <= r_base[hit_idx];
            r_result.size <= r_size[hit_idx];
        end
    end

    assign o_result = r_result;

endmodule

// ===== rtl/segment_address_translation_core.sv =====
// Segment address translation core. Each input item is either a table load
// (action 0: writes slot entry_slot with id, base, size and valid) or a
// translate (action 1: splits logical_address by max_segment_size into a
// segment number and offset, finds the lowest live slot whose id equals the
// segment number, and returns base + offset unless no slot matches or
// offset + byte_count exceeds the slot size, in which case fault is set and
// physical_address is zero). Every item gives exactly one result item; a load
// returns all zeros. A translate passes from acceptance through the
// bit-serial restoring divider, which produces one quotient bit per cycle,
// a step to see the divider finish, table match, limit check, a move of the
// result into the output register, which waits until that register is free,
// and a return to idle, before which no new item is taken.
// A load goes straight from idle to the output move. A zero max_segment_size
// yields segment number 0xFFFF and offset equal to the address, which always
// faults. max_segment_size resets to 64 and may be written only while the core
// is idle; its write port is always ready.
module segment_address_translation_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sat_pkg::DATA_W-1:0]   i_cfg_data,

    // Input item channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [sat_pkg::DATA_W-1:0]   i_logical_address,
    input  logic [sat_pkg::DATA_W-1:0]   i_byte_count,
    input  logic [sat_pkg::SLOT_W-1:0]   i_entry_slot,
    input  logic [sat_pkg::ID_W-1:0]     i_entry_id,
    input  logic [sat_pkg::DATA_W-1:0]   i_entry_base,
    input  logic [sat_pkg::DATA_W-1:0]   i_entry_size,
    input  logic                         i_entry_valid,

    // Result item channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sat_pkg::DATA_W-1:0]   o_physical_address,
    output logic                         o_fault,
    output logic [sat_pkg::DATA_W-1:0]   o_segment_number,
    output logic [sat_pkg::DATA_W-1:0]   o_offset
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MATCH = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [sat_pkg::DATA_W-1:0] r_max_seg;
    logic [sat_pkg::DATA_W-1:0] r_count;

    // Finished result waiting for the output register
    logic [sat_pkg::DATA_W-1:0] r_res_phys;
    logic                       r_res_fault;
    logic [sat_pkg::DATA_W-1:0] r_res_seg;
    logic [sat_pkg::DATA_W-1:0] r_res_off;

    // Output register
    logic                       r_out_valid;
    logic [sat_pkg::DATA_W-1:0] r_out_phys;
    logic                       r_out_fault;
    logic [sat_pkg::DATA_W-1:0] r_out_seg;
    logic [sat_pkg::DATA_W-1:0] r_out_off;

    logic                       in_fire;
    logic                       out_free;
    logic                       div_start;
    sat_pkg::t_div_status       div_status;
    logic [sat_pkg::DATA_W-1:0] quotient;
    logic [sat_pkg::DATA_W-1:0] remainder;
    sat_pkg::t_slot_write       slot_write;
    sat_pkg::t_lookup_result    lookup;
    logic [sat_pkg::DATA_W:0]   limit_sum;
    logic [sat_pkg::DATA_W:0]   phys_sum;
    logic                       over_limit;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign div_start   = in_fire && (i_action == sat_pkg::ACT_TRANSLATE);

    // Configuration register: divisor for the segment/offset split
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seg <= sat_pkg::MAX_SEG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_seg <= i_cfg_data;
        end
    end

    // Table write on a load item; slots beyond the table are dropped
    always_comb begin
        slot_write.en          = in_fire && (i_action == sat_pkg::ACT_LOAD) &&
                                 (32'(i_entry_slot) < sat_pkg::SEGMENTS);
        slot_write.slot        = sat_pkg::SLOT_IDX_W'(i_entry_slot);
        slot_write.entry.valid = i_entry_valid;
        slot_write.entry.id    = i_entry_id;
        slot_write.entry.base  = i_entry_base;
        slot_write.entry.size  = i_entry_size;
    end

    sat_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_logical_address),
        .i_divisor   (r_max_seg),
        .o_status    (div_status),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    sat_lookup u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (slot_write),
        .i_search (r_state == S_MATCH),
        .i_key    (quotient),
        .o_result (lookup)
    );

    // Limit check is done one bit wider so offset + count cannot overflow.
    assign limit_sum  = {1'b0, remainder} + {1'b0, r_count};
    assign over_limit = limit_sum > {1'b0, lookup.size};
    assign phys_sum   = ({1'b0, lookup.base} + {1'b0, remainder}) & sat_pkg::ADDR_MASK;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_action == sat_pkg::ACT_TRANSLATE) ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: n_state = S_CHECK;
            S_CHECK: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the byte count and build the pending result
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_count <= i_byte_count;
        end
        if (in_fire && (i_action == sat_pkg::ACT_LOAD)) begin
            r_res_phys  <= '0;
            r_res_fault <= 1'b0;
            r_res_seg   <= '0;
            r_res_off   <= '0;
        end else if (r_state == S_CHECK) begin
            r_res_fault <= !lookup.hit || over_limit;
            r_res_phys  <= (!lookup.hit || over_limit) ? '0
                                                       : phys_sum[sat_pkg::DATA_W-1:0];
            r_res_seg   <= quotient;
            r_res_off   <= remainder;
        end
    end

    // Output register: advance the pending item once the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_phys  <= r_res_phys;
            r_out_fault <= r_res_fault;
            r_out_seg   <= r_res_seg;
            r_out_off   <= r_res_off;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_phys;
    assign o_fault            = r_out_fault;
    assign o_segment_number   = r_out_seg;
    assign o_offset           = r_out_off;

    // A faulting item never carries a physical address.
    a_fault_zero_phys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_physical_address == '0))
        else $error("fault result with nonzero physical address");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.done |-> (r_state == S_DIV))
        else $error("divider done outside the divide phase");

    // No new item is taken while the divider is still stepping.
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !div_status.busy)
        else $error("input ready while divider busy");

    // An accepted translate starts the divider on the next cycle.
    a_translate_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action == sat_pkg::ACT_TRANSLATE))
            |=> (div_status.busy && (r_state == S_DIV)))
        else $error("translate item did not start the divider");

endmodule

// ===== sim/segment_address_translation_core_tb.sv =====
`timescale 1ns / 1ps

module segment_address_translation_core_tb;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int STALL_LIMIT     = 4000;  // cycles with no handshake on any channel
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off for the pressure test
    localparam int SETTLE_CYCLES   = 30;    // a little more than one translate
    localparam int RANDOM_ITEMS    = 1300;

    // One request as it crosses the input channel
    typedef struct packed {
        logic                       action;
        logic [sat_pkg::DATA_W-1:0] addr;
        logic [sat_pkg::DATA_W-1:0] count;
        logic [sat_pkg::SLOT_W-1:0] slot;
        logic [sat_pkg::ID_W-1:0]   id;
        logic [sat_pkg::DATA_W-1:0] base;
        logic [sat_pkg::DATA_W-1:0] size;
        logic                       live;
    } t_seg_request;

    // One answer as it leaves the result channel
    typedef struct packed {
        logic [sat_pkg::DATA_W-1:0] phys;
        logic                       fault;
        logic [sat_pkg::DATA_W-1:0] seg;
        logic [sat_pkg::DATA_W-1:0] off;
    } t_seg_answer;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [sat_pkg::DATA_W-1:0]   i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_action;
    logic [sat_pkg::DATA_W-1:0]   i_logical_address;
    logic [sat_pkg::DATA_W-1:0]   i_byte_count;
    logic [sat_pkg::SLOT_W-1:0]   i_entry_slot;
    logic [sat_pkg::ID_W-1:0]     i_entry_id;
    logic [sat_pkg::DATA_W-1:0]   i_entry_base;
    logic [sat_pkg::DATA_W-1:0]   i_entry_size;
    logic                         i_entry_valid;
    logic                         o_valid;
    logic                         i_ready;
    logic [sat_pkg::DATA_W-1:0]   o_physical_address;
    logic                         o_fault;
    logic [sat_pkg::DATA_W-1:0]   o_segment_number;
    logic [sat_pkg::DATA_W-1:0]   o_offset;

    // Predictor copy of the segment table and the divisor register
    logic                       tbl_live [sat_pkg::SEGMENTS];
    logic [sat_pkg::ID_W-1:0]   tbl_id   [sat_pkg::SEGMENTS];
    logic [sat_pkg::DATA_W-1:0] tbl_base [sat_pkg::SEGMENTS];
    logic [sat_pkg::DATA_W-1:0] tbl_size [sat_pkg::SEGMENTS];
    logic [sat_pkg::DATA_W-1:0] seg_divisor;

    t_seg_answer pending_answers[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          allow_idle     = 1'b1;  // clear for stretches at full rate
    bit          hold_off_req   = 1'b0;  // ask the receiver for one long hold-off
    int          hold_left      = 0;
    int          stall_left     = 0;

    segment_address_translation_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_logical_address  (i_logical_address),
        .i_byte_count       (i_byte_count),
        .i_entry_slot       (i_entry_slot),
        .i_entry_id         (i_entry_id),
        .i_entry_base       (i_entry_base),
        .i_entry_size       (i_entry_size),
        .i_entry_valid      (i_entry_valid),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_physical_address (o_physical_address),
        .o_fault            (o_fault),
        .o_segment_number   (o_segment_number),
        .o_offset           (o_offset)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Apply one accepted request to the table copy and return its answer.
    // A load answers all zeros. A translate splits the address by the
    // divisor (zero divisor: quotient all ones, remainder = address), takes
    // the lowest live slot with a matching id, and faults on a miss or when
    // offset + count runs past the slot size (compared at 17 bits).
    function automatic t_seg_answer predict_translation(input t_seg_request req);
        t_seg_answer              ans;
        int                       hit;
        logic [sat_pkg::DATA_W:0] sum;
        ans = '0;
        hit = -1;
        if (req.action == sat_pkg::ACT_LOAD) begin
            if (int'(req.slot) < sat_pkg::SEGMENTS) begin
                tbl_live[req.slot] = req.live;
                tbl_id[req.slot]   = req.id;
                tbl_base[req.slot] = req.base;
                tbl_size[req.slot] = req.size;
            end
            return ans;
        end
        if (seg_divisor == '0) begin
            ans.seg = '1;
            ans.off = req.addr;
        end else begin
            ans.seg = req.addr / seg_divisor;
            ans.off = req.addr % seg_divisor;
        end
        for (int i = 0; i < sat_pkg::SEGMENTS; i++) begin
            if (hit < 0 && tbl_live[i] && {8'h00, tbl_id[i]} == ans.seg) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            ans.fault = 1'b1;
        end else if (({1'b0, ans.off} + {1'b0, req.count}) > {1'b0, tbl_size[hit]}) begin
            ans.fault = 1'b1;
        end else begin
            sum      = ({1'b0, tbl_base[hit]} + {1'b0, ans.off}) & sat_pkg::ADDR_MASK;
            ans.phys = sum[sat_pkg::DATA_W-1:0];
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Request builders and idle lengths
    // ------------------------------------------------------------------

    function automatic t_seg_request load_req(input int slot, input int id, input int base,
                                              input int size, input bit live);
        t_seg_request req;
        req        = '0;
        req.action = sat_pkg::ACT_LOAD;
        req.slot   = sat_pkg::SLOT_W'(slot);
        req.id     = sat_pkg::ID_W'(id);
        req.base   = sat_pkg::DATA_W'(base);
        req.size   = sat_pkg::DATA_W'(size);
        req.live   = live;
        // Noise on the fields a load ignores
        req.addr   = sat_pkg::DATA_W'($urandom);
        req.count  = sat_pkg::DATA_W'($urandom);
        return req;
    endfunction

    function automatic t_seg_request xlat_req(input int addr, input int count);
        t_seg_request req;
        req        = t_seg_request'({$urandom, $urandom, $urandom});
        req.action = sat_pkg::ACT_TRANSLATE;
        req.addr   = sat_pkg::DATA_W'(addr);
        req.count  = sat_pkg::DATA_W'(count);
        return req;
    endfunction

    // Mostly back to back, often a short gap, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, predict its answer at the
    // accepting edge, then maybe drop valid for a gap.
    task automatic send_item(input t_seg_request req);
        int gap;
        i_action          <= req.action;
        i_logical_address <= req.addr;
        i_byte_count      <= req.count;
        i_entry_slot      <= req.slot;
        i_entry_id        <= req.id;
        i_entry_base      <= req.base;
        i_entry_size      <= req.size;
        i_entry_valid     <= req.live;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_answers.push_back(predict_translation(req));
        gap = allow_idle ? idle_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding answer
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Write the divisor register with the core idle
    task automatic set_divisor(input logic [sat_pkg::DATA_W-1:0] value);
        drain_block();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seg_divisor = value;
    endtask

    // Highest id whose segment still starts inside the 16-bit address space
    function automatic int id_ceiling();
        if (seg_divisor == '0) return 255;
        return (65535 / int'(seg_divisor)) < 255 ? 65535 / int'(seg_divisor) : 255;
    endfunction

    function automatic t_seg_request random_load();
        int id;
        int size;
        int div;
        div  = int'(seg_divisor);
        id   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, id_ceiling())
                                          : $urandom_range(0, 255);
        size = ($urandom_range(0, 1) == 0) ? $urandom_range(0, (2 * div + 16 < 65535) ?
                                                                2 * div + 16 : 65535)
                                           : $urandom_range(0, 65535);
        return load_req($urandom_range(0, sat_pkg::SEGMENTS - 1), id,
                        $urandom_range(0, 65535), size, $urandom_range(0, 99) < 85);
    endfunction

    // Aim a translate at a live slot, with the count near the limit edge
    function automatic t_seg_request aimed_translate();
        int s;
        int lo;
        int span;
        int off;
        int room;
        int count;
        s = $urandom_range(0, sat_pkg::SEGMENTS - 1);
        if (!tbl_live[s] || seg_divisor == '0)
            return xlat_req($urandom_range(0, 65535), $urandom_range(0, 65535));
        lo = int'(tbl_id[s]) * int'(seg_divisor);
        if (lo > 65535)
            return xlat_req($urandom_range(0, 65535), $urandom_range(0, 65535));
        span = (int'(seg_divisor) - 1 < 65535 - lo) ? int'(seg_divisor) - 1 : 65535 - lo;
        off  = $urandom_range(0, span);
        if (off > int'(tbl_size[s])) begin
            count = $urandom_range(0, 65535);
        end else begin
            room = int'(tbl_size[s]) - off;
            case ($urandom_range(0, 2))
                0: count = room;
                1: count = (room < 65535) ? room + 1 : room;
                default: count = $urandom_range(0, room);
            endcase
        end
        return xlat_req(lo + off, count);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh table: every slot is dead, so even id 0 must miss
    task automatic test_empty_table();
        send_item(xlat_req(16'h0000, 16'h0000));
        send_item(xlat_req(16'hFFFF, 16'hFFFF));
    endtask

    // Lookup priority, exact-fit limits, wrap of base + offset, empty segments
    task automatic test_slot_lookup();
        send_item(load_req(0, 8'h05, 16'h1000, 16'h0040, 1'b1));
        send_item(load_req(15, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(load_req(3, 8'h05, 16'h2000, 16'h0100, 1'b1));
        // id 5, offset 10: 10 + 54 fits exactly, 10 + 55 does not (slot 0 wins)
        send_item(xlat_req(5 * 64 + 10, 54));
        send_item(xlat_req(5 * 64 + 10, 55));
        // Kill slot 0; the same access now lands in slot 3
        send_item(load_req(0, 8'h05, 16'h1000, 16'h0040, 1'b0));
        send_item(xlat_req(5 * 64 + 10, 55));
        // Top id, top base: sum wraps; the limit sum must not wrap
        send_item(xlat_req(255 * 64 + 63, 16'hFFFF - 63));
        send_item(xlat_req(255 * 64 + 63, 16'hFFFF));
        // Zero-size segment admits only a zero-length access at offset 0
        send_item(load_req(7, 8'h09, 16'h1234, 16'h0000, 1'b1));
        send_item(xlat_req(9 * 64, 0));
        send_item(xlat_req(9 * 64, 1));
        send_item(load_req(1, 8'h00, 16'h00AA, 16'h0010, 1'b1));
        send_item(xlat_req(0, 0));
    endtask

    // Divisor of zero, one and all ones, then back to the reset value
    task automatic test_divisor_extremes();
        set_divisor(16'd0);
        send_item(xlat_req(16'h0000, 0));
        send_item(xlat_req(16'hFFFF, 0));
        set_divisor(16'd1);
        send_item(xlat_req(5, 0));
        send_item(xlat_req(255, 0));
        send_item(xlat_req(16'hFFFF, 0));
        set_divisor(16'hFFFF);
        send_item(load_req(2, 8'h01, 16'h4000, 16'h0010, 1'b1));
        send_item(xlat_req(16'hFFFF, 0));
        send_item(xlat_req(16'hFFFE, 1));
        set_divisor(16'd64);
    endtask

    // Phases of random traffic, each under its own divisor: seed the table
    // with reachable ids, then mostly aimed translates with loads mixed in.
    task automatic test_random_traffic();
        logic [sat_pkg::DATA_W-1:0] divisors [10];
        int                         per_phase;
        int                         r;
        divisors  = '{16'd64, 16'd1, 16'd3, 16'd100, 16'd256,
                      sat_pkg::DATA_W'($urandom_range(1, 65535)), 16'd4096, 16'hFFFF, 16'd0,
                      sat_pkg::DATA_W'($urandom_range(2, 40))};
        per_phase = RANDOM_ITEMS / 10;
        foreach (divisors[p]) begin
            set_divisor(divisors[p]);
            // Run one phase at full rate on the sender side
            allow_idle = (p != 4);
            for (int k = 0; k < per_phase; k++) begin
                r = $urandom_range(0, 99);
                if (k < 6 || r < 15)
                    send_item(random_load());
                else if (r < 85)
                    send_item(aimed_translate());
                else
                    send_item(xlat_req($urandom_range(0, 65535), $urandom_range(0, 65535)));
            end
            allow_idle = 1'b1;
        end
    endtask

    // Hold the receiver off while items keep coming so the core backs up
    task automatic test_output_backpressure();
        drain_block();
        allow_idle   = 1'b0;
        hold_off_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
            if (k % 3 == 0)
                send_item(random_load());
            else
                send_item(aimed_translate());
        end
        allow_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 99) < 30) begin
            stall_left = idle_length();
            i_ready    <= (stall_left == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: match every answer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_seg_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item phys=%h fault=%b seg=%h off=%h",
                         $time, o_physical_address, o_fault, o_segment_number, o_offset);
            end else begin
                want = pending_answers.pop_front();
                if (o_physical_address !== want.phys) begin
                    mismatch_count++;
                    $display("%0t: physical_address expected %h got %h",
                             $time, want.phys, o_physical_address);
                end
                if (o_fault !== want.fault) begin
                    mismatch_count++;
                    $display("%0t: fault expected %b got %b", $time, want.fault, o_fault);
                end
                if (o_segment_number !== want.seg) begin
                    mismatch_count++;
                    $display("%0t: segment_number expected %h got %h",
                             $time, want.seg, o_segment_number);
                end
                if (o_offset !== want.off) begin
                    mismatch_count++;
                    $display("%0t: offset expected %h got %h", $time, want.off, o_offset);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no channel has moved for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_answers.size());
            $display("FAIL segment_address_translation_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Known values on every input from time zero
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_ready           = 1'b0;
        i_action          = sat_pkg::ACT_LOAD;
        i_logical_address = '0;
        i_byte_count      = '0;
        i_entry_slot      = '0;
        i_entry_id        = '0;
        i_entry_base      = '0;
        i_entry_size      = '0;
        i_entry_valid     = 1'b0;
        seg_divisor       = sat_pkg::MAX_SEG_RESET;
        for (int i = 0; i < sat_pkg::SEGMENTS; i++) begin
            tbl_live[i] = 1'b0;
            tbl_id[i]   = '0;
            tbl_base[i] = '0;
            tbl_size[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_slot_lookup();
        test_divisor_extremes();
        test_random_traffic();
        test_output_backpressure();

        // Let the last answers out, then allow a little settle time
        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("PASS segment_address_translation_core");
        end else begin
            $display("FAIL segment_address_translation_core");
        end
        $finish;
    end

endmodule
